[src/boris_particle_push_assert.svh]
// assertion macros for the boris particle pusher
// used by boris_particle_push.sv, no other dependencies
`ifndef BORIS_PARTICLE_PUSH_ASSERT_SVH
`define BORIS_PARTICLE_PUSH_ASSERT_SVH
`ifndef SYNTHESIS
`define BPP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bpp check failed");
`define BPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpp check failed");
`else
`define BPP_ASSERT(lbl, clk, rst, prop)
`define BPP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[src/bpp_pkg.sv]
// types, constants and helpers for the boris particle pusher
// no dependencies
package bpp_pkg;

   localparam int QUO_W  = 30;
   localparam int DEN_W  = 36;
   localparam int NUM_W  = 61;
   localparam int ADDR_W = 3;

   localparam int CROSS_A [3] = '{1, 2, 0};
   localparam int CROSS_B [3] = '{2, 0, 1};

   typedef enum logic {
      REG_K  = 1'b0,
      REG_DT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] efield_x;
      logic signed [31:0] efield_y;
      logic signed [31:0] efield_z;
      logic signed [31:0] bfield_x;
      logic signed [31:0] bfield_y;
      logic signed [31:0] bfield_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [31:0] k;
      logic [31:0]        dt;
   } cfg_type;

   typedef logic [2:0][31:0] vec_type;

   typedef struct packed {
      vec_type          pos;
      logic [2:0][33:0] de;
      vec_type          vm;
      vec_type          vp;
   } carry_type;

   typedef struct packed {
      logic [2:0]       neg;
      vec_type          tmag;
      logic [DEN_W-1:0] den;
   } div_in_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
      logic signed [31:0] r;
      if (x > 48'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -48'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

[src/bpp_front.sv]
// front stages: half kick, rotation vector, squares and first cross product
// depends on bpp_pkg
module bpp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  bpp_pkg::req_payload_type in_data,
   input  bpp_pkg::cfg_type         cfg,
   output logic                     out_valid,
   output bpp_pkg::carry_type       out_carry,
   output bpp_pkg::div_in_type      out_div
);

   logic [3:0] valid_ff;

   bpp_pkg::vec_type e_vec, b_vec, p_vec, v_vec;

   logic signed [63:0] ek_in [3];
   logic signed [63:0] bk_in [3];
   logic signed [63:0] ek_ff [3];
   logic signed [63:0] bk_ff [3];
   bpp_pkg::vec_type   pos1_ff, vel1_ff;

   logic signed [33:0] de_in [3];
   logic signed [31:0] vm_in [3];
   logic signed [31:0] t_in  [3];
   logic signed [33:0] de2_ff [3];
   logic signed [31:0] vm2_ff [3];
   logic signed [31:0] t2_ff  [3];
   bpp_pkg::vec_type   pos2_ff;

   logic signed [63:0] sq_in [3];
   logic signed [63:0] p_in  [6];
   logic signed [63:0] sq3_ff [3];
   logic signed [63:0] p3_ff  [6];
   logic signed [33:0] de3_ff [3];
   logic signed [31:0] vm3_ff [3];
   logic signed [31:0] t3_ff  [3];
   bpp_pkg::vec_type   pos3_ff;

   logic [63:0]                 tsq;
   logic signed [35:0]          rr [6];
   logic signed [36:0]          cx [3];
   bpp_pkg::carry_type          carry_in, carry_ff;
   bpp_pkg::div_in_type         div_in, div_ff;

   assign e_vec = {in_data.efield_z, in_data.efield_y, in_data.efield_x};
   assign b_vec = {in_data.bfield_z, in_data.bfield_y, in_data.bfield_x};
   assign p_vec = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
   assign v_vec = {in_data.vel_z, in_data.vel_y, in_data.vel_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ek_in[i] = 64'($signed(e_vec[i])) * 64'(cfg.k);
         bk_in[i] = 64'($signed(b_vec[i])) * 64'(cfg.k);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         de_in[i] = 34'((ek_ff[i] + 64'sd536870912) >>> 30);
         vm_in[i] = bpp_pkg::sat32(48'($signed(vel1_ff[i])) + 48'(de_in[i]));
         t_in[i]  = bpp_pkg::sat32(48'((bk_ff[i] + 64'sd131072) >>> 18));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i]     = 64'(t2_ff[i]) * 64'(t2_ff[i]);
         p_in[2*i]    = 64'(vm2_ff[bpp_pkg::CROSS_A[i]]) * 64'(t2_ff[bpp_pkg::CROSS_B[i]]);
         p_in[2*i+1]  = 64'(vm2_ff[bpp_pkg::CROSS_B[i]]) * 64'(t2_ff[bpp_pkg::CROSS_A[i]]);
      end
   end

   always_comb begin
      tsq = 64'(unsigned'(sq3_ff[0])) + 64'(unsigned'(sq3_ff[1]))
          + 64'(unsigned'(sq3_ff[2]));
      div_in.den = bpp_pkg::DEN_W'(tsq[63:28]) + bpp_pkg::DEN_W'(64'd1 << 28);
      for (int j = 0; j < 6; j++) begin
         rr[j] = 36'((p3_ff[j] + 64'sd134217728) >>> 28);
      end
      for (int i = 0; i < 3; i++) begin
         cx[i] = 37'(rr[2*i]) - 37'(rr[2*i+1]);
         carry_in.pos[i] = pos3_ff[i];
         carry_in.de[i]  = de3_ff[i];
         carry_in.vm[i]  = vm3_ff[i];
         carry_in.vp[i]  = bpp_pkg::sat32(48'(vm3_ff[i]) + 48'(cx[i]));
         div_in.neg[i]   = t3_ff[i][31];
         div_in.tmag[i]  = t3_ff[i][31] ? (~t3_ff[i] + 32'd1) : t3_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            ek_ff[i]  <= ek_in[i];
            bk_ff[i]  <= bk_in[i];
            de2_ff[i] <= de_in[i];
            vm2_ff[i] <= vm_in[i];
            t2_ff[i]  <= t_in[i];
            sq3_ff[i] <= sq_in[i];
            de3_ff[i] <= de2_ff[i];
            vm3_ff[i] <= vm2_ff[i];
            t3_ff[i]  <= t2_ff[i];
         end
         for (int j = 0; j < 6; j++) begin
            p3_ff[j] <= p_in[j];
         end
         pos1_ff  <= p_vec;
         vel1_ff  <= v_vec;
         pos2_ff  <= pos1_ff;
         pos3_ff  <= pos2_ff;
         carry_ff <= carry_in;
         div_ff   <= div_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_carry = carry_ff;
   assign out_div   = div_ff;

endmodule

[src/bpp_div.sv]
// pipelined restoring divider for s = 2t / (1 + |t|^2), one quotient bit per stage
// depends on bpp_pkg
module bpp_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  bpp_pkg::carry_type  in_carry,
   input  bpp_pkg::div_in_type in_div,
   output logic                out_valid,
   output bpp_pkg::carry_type  out_carry,
   output bpp_pkg::vec_type    out_s
);

   localparam int QW = bpp_pkg::QUO_W;
   localparam int DW = bpp_pkg::DEN_W;
   localparam int NW = bpp_pkg::NUM_W;

   typedef struct packed {
      logic [2:0][DW-1:0] rem;
      logic [2:0][QW-1:0] nlo;
      logic [2:0][QW-1:0] quo;
      logic [DW-1:0]      den;
      logic [2:0]         neg;
      bpp_pkg::carry_type carry;
   } div_stage_type;

   div_stage_type stage_in [QW+1];
   div_stage_type stage_ff [QW+1];
   logic [QW:0]   valid_ff;
   logic [NW-1:0] num [3];

   always_comb begin
      stage_in[0].den   = in_div.den;
      stage_in[0].neg   = in_div.neg;
      stage_in[0].carry = in_carry;
      for (int i = 0; i < 3; i++) begin
         num[i] = NW'({in_div.tmag[i], 29'b0}) + NW'(in_div.den >> 1);
         stage_in[0].rem[i] = DW'(num[i][NW-1:QW]);
         stage_in[0].nlo[i] = num[i][QW-1:0];
         stage_in[0].quo[i] = '0;
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_step
      logic [2:0][DW:0] trial;
      logic [2:0]       ge;
      always_comb begin
         stage_in[j] = stage_ff[j-1];
         for (int i = 0; i < 3; i++) begin
            trial[i] = {stage_ff[j-1].rem[i], stage_ff[j-1].nlo[i][QW-1]};
            ge[i]    = trial[i] >= {1'b0, stage_ff[j-1].den};
            stage_in[j].rem[i] = ge[i] ? DW'(trial[i] - {1'b0, stage_ff[j-1].den})
                                       : DW'(trial[i]);
            stage_in[j].nlo[i] = stage_ff[j-1].nlo[i] << 1;
            stage_in[j].quo[i] = {stage_ff[j-1].quo[i][QW-2:0], ge[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[QW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_s[i] = stage_ff[QW].neg[i] ? (32'd0 - 32'(stage_ff[QW].quo[i]))
                                        : 32'(stage_ff[QW].quo[i]);
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_carry = stage_ff[QW].carry;

endmodule

[src/bpp_rotate.sv]
// back stages: second cross product, second half kick and position advance
// depends on bpp_pkg
module bpp_rotate (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  bpp_pkg::carry_type       in_carry,
   input  bpp_pkg::vec_type         in_s,
   input  bpp_pkg::cfg_type         cfg,
   output logic                     out_valid,
   output bpp_pkg::rsp_payload_type out_data
);

   logic [3:0] valid_ff;

   logic signed [63:0] p_in [6];
   logic signed [63:0] p1_ff [6];
   bpp_pkg::carry_type carry1_ff;

   logic signed [35:0] rr [6];
   logic signed [36:0] cx [3];
   logic signed [31:0] vpl [3];
   logic signed [31:0] nv_in [3];
   logic signed [31:0] nv2_ff [3];
   bpp_pkg::vec_type   pos2_ff;

   logic signed [64:0] pd_in [3];
   logic signed [64:0] pd3_ff [3];
   logic signed [31:0] nv3_ff [3];
   bpp_pkg::vec_type   pos3_ff;

   logic signed [31:0]        np [3];
   bpp_pkg::rsp_payload_type  out_in, out_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_in[2*i]   = 64'($signed(in_carry.vp[bpp_pkg::CROSS_A[i]]))
                     * 64'($signed(in_s[bpp_pkg::CROSS_B[i]]));
         p_in[2*i+1] = 64'($signed(in_carry.vp[bpp_pkg::CROSS_B[i]]))
                     * 64'($signed(in_s[bpp_pkg::CROSS_A[i]]));
      end
   end

   always_comb begin
      for (int j = 0; j < 6; j++) begin
         rr[j] = 36'((p1_ff[j] + 64'sd134217728) >>> 28);
      end
      for (int i = 0; i < 3; i++) begin
         cx[i]    = 37'(rr[2*i]) - 37'(rr[2*i+1]);
         vpl[i]   = bpp_pkg::sat32(48'($signed(carry1_ff.vm[i])) + 48'(cx[i]));
         nv_in[i] = bpp_pkg::sat32(48'(vpl[i]) + 48'($signed(carry1_ff.de[i])));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pd_in[i] = 65'(nv2_ff[i]) * 65'($signed({1'b0, cfg.dt}));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         np[i] = bpp_pkg::sat32(48'($signed(pos3_ff[i]))
                              + 48'((pd3_ff[i] + 65'sd8388608) >>> 24));
      end
      out_in.new_pos_x = np[0];
      out_in.new_pos_y = np[1];
      out_in.new_pos_z = np[2];
      out_in.new_vel_x = nv3_ff[0];
      out_in.new_vel_y = nv3_ff[1];
      out_in.new_vel_z = nv3_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 6; j++) begin
            p1_ff[j] <= p_in[j];
         end
         for (int i = 0; i < 3; i++) begin
            nv2_ff[i] <= nv_in[i];
            pd3_ff[i] <= pd_in[i];
            nv3_ff[i] <= nv2_ff[i];
         end
         carry1_ff <= in_carry;
         pos2_ff   <= carry1_ff.pos;
         pos3_ff   <= pos2_ff;
         out_ff    <= out_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_data  = out_ff;

endmodule

[src/boris_particle_push.sv]
// boris particle pusher, top level: config registers and pipeline control
// fully pipelined from accepted request to response, one transaction per cycle unless a response is stalled
// the divider in bpp_div sets the depth, one quotient bit per stage
// the whole pipeline holds while a response is stalled
// synchronous reset clears valid bits and both config registers
// depends on bpp_pkg, bpp_front, bpp_div, bpp_rotate and the assertion header
`include "boris_particle_push_assert.svh"
module boris_particle_push (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bpp_pkg::req_payload_type      req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bpp_pkg::rsp_payload_type      rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bpp_pkg::ADDR_W-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic signed [31:0]  k_ff;
   logic [31:0]         dt_ff;
   bpp_pkg::cfg_type    cfg;
   logic                en;
   logic                csr_wr;

   logic                front_valid, div_valid;
   bpp_pkg::carry_type  front_carry, div_carry;
   bpp_pkg::div_in_type front_div;
   bpp_pkg::vec_type    div_s;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign cfg.k     = k_ff;
   assign cfg.dt    = dt_ff;
   assign prdata    = (paddr[2] == bpp_pkg::REG_DT) ? dt_ff : k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff  <= '0;
         dt_ff <= '0;
      end else if (csr_wr) begin
         unique case (bpp_pkg::reg_index_type'(paddr[2]))
            bpp_pkg::REG_K:  k_ff  <= pwdata;
            bpp_pkg::REG_DT: dt_ff <= pwdata;
            default: ;
         endcase
      end
   end

   bpp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .cfg       (cfg),
      .out_valid (front_valid),
      .out_carry (front_carry),
      .out_div   (front_div)
   );

   bpp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_carry  (front_carry),
      .in_div    (front_div),
      .out_valid (div_valid),
      .out_carry (div_carry),
      .out_s     (div_s)
   );

   bpp_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_carry  (div_carry),
      .in_s      (div_s),
      .cfg       (cfg),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   `BPP_ASSERT(a_stall_needs_rsp, clock, reset, req_stall |-> rsp_valid)
   `BPP_ASSERT_NEXT(a_k_write, clock, reset, csr_wr && paddr[2] == bpp_pkg::REG_K, k_ff == $past(pwdata))
   `BPP_ASSERT_NEXT(a_dt_write, clock, reset, csr_wr && paddr[2] == bpp_pkg::REG_DT, dt_ff == $past(pwdata))

endmodule
